// ===== sv/sidr_pkg.sv =====
// ----------------------------------------------------------------------------
// sidr_pkg
// Types, constants and helpers shared by the radix digit converter files.
// ----------------------------------------------------------------------------
package sidr_pkg;

    // Field widths fixed by the item formats
    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 8;
    localparam int RADIX_W    = 5;
    localparam int SYM_W      = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int NUM_SYMS   = 16;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [CHAR_W-1:0]         t_char;
    typedef logic [SYM_W-1:0]          t_cfg_data;
    typedef logic [CFG_IDX_W-1:0]      t_cfg_addr;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIX    = 2'd0,
        CFG_SYM_LOW  = 2'd1,
        CFG_SYM_HIGH = 2'd2
    } t_cfg_idx;

    // Special characters
    localparam t_char CH_MINUS = 8'h2D;
    localparam t_char CH_PLUS  = 8'h2B;

    // Converter sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_SIGN,
        ST_DIGIT
    } t_state;

    // Symbol byte for digit value d from the two 64-bit symbol words
    function automatic t_char sym_of(input logic [SYM_W-1:0] lo,
                                     input logic [SYM_W-1:0] hi,
                                     input logic [3:0]       d);
        t_char res;
        if (d[3]) begin
            res = hi[{d[2:0], 3'b000} +: CHAR_W];
        end else begin
            res = lo[{d[2:0], 3'b000} +: CHAR_W];
        end
        return res;
    endfunction

endpackage

// ===== sv/sidr_if.sv =====
// ----------------------------------------------------------------------------
// sidr_if
// Valid/ready channel interfaces: value input, character output, config write.
// ----------------------------------------------------------------------------
interface sidr_value_if;
    logic            valid;
    logic            ready;
    sidr_pkg::t_value value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sidr_char_if;
    logic            valid;
    logic            ready;
    sidr_pkg::t_char character;
    logic            last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

interface sidr_cfg_if;
    logic                valid;
    logic                ready;
    sidr_pkg::t_cfg_addr index;
    sidr_pkg::t_cfg_data data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/signed_integer_to_radix_digits_core.sv =====
// ----------------------------------------------------------------------------
// signed_integer_to_radix_digits_core
// Converts a signed 32-bit value to its text in a configured radix, one
// character beat per symbol, using a bit-serial restoring divider.
// ----------------------------------------------------------------------------
//  channel     dir  beat contents          notes
//  i_value_ch  in   value (32b signed)     taken only while the sequencer idles
//  o_char_ch   out  character (8b), last   registered, last on final symbol
//  i_cfg_ch    in   index (2b), data (64b) always ready
//
//  Per value: a symbol check over the r symbols in use (one symbol a cycle),
//  a bit-serial divide per digit (one quotient bit a cycle), then the
//  characters, r the radix in use.
//  Reset is synchronous, active low, and clears config and control state.
//  A stalled output holds the sequencer in its emit state; the next value is
//  accepted while the final character still waits in the output register.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_digits_core #(
    parameter int MAX_RADIX = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    sidr_value_if.sink         i_value_ch,
    sidr_char_if.source        o_char_ch,
    sidr_cfg_if.sink           i_cfg_ch
);
    import sidr_pkg::*;

    localparam int RW    = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1; // digit width
    localparam int RAD_W = $clog2(MAX_RADIX + 1);                   // radix in use
    localparam int STK_W = VALUE_W * RW;                            // digit stack
    localparam int CNT_W = $clog2(VALUE_W + 1);                     // digit count
    localparam int BIT_W = $clog2(VALUE_W);                         // divide step

    // Configuration registers
    logic [RADIX_W-1:0] r_radix, n_radix;
    t_cfg_data          r_sym_lo, n_sym_lo;
    t_cfg_data          r_sym_hi, n_sym_hi;

    // Sequencer and datapath
    t_state             r_state, n_state;
    logic               r_neg, n_neg;
    logic [VALUE_W-1:0] r_q, n_q;
    logic [RW-1:0]      r_rem, n_rem;
    logic [BIT_W-1:0]   r_bit, n_bit;
    logic [RW-1:0]      r_idx, n_idx;
    logic [STK_W-1:0]   r_stk, n_stk;
    logic [CNT_W-1:0]   r_nd, n_nd;

    // Output register
    logic               r_out_valid, n_out_valid;
    t_char              r_char, n_char;
    logic               r_last, n_last;

    logic [RAD_W-1:0]   used_radix;
    logic [RW:0]        rad_ext;
    logic [RW:0]        rem_sh;
    logic               q_bit;
    logic [RW-1:0]      rem_new;
    logic [VALUE_W-1:0] q_new;
    t_char              chk_sym;
    logic               sym_bad;
    logic               out_free;

    // Radix clamped to the table limit
    always_comb begin
        if (r_radix > RADIX_W'(MAX_RADIX)) begin
            used_radix = RAD_W'(MAX_RADIX);
        end else begin
            used_radix = RAD_W'(r_radix);
        end
    end

    // One restoring divide step
    assign rad_ext = (RW+1)'(used_radix);
    assign rem_sh  = {r_rem, r_q[VALUE_W-1]};
    assign q_bit   = (rem_sh >= rad_ext);
    assign rem_new = q_bit ? RW'(rem_sh - rad_ext) : RW'(rem_sh);
    assign q_new   = {r_q[VALUE_W-2:0], q_bit};

    // Symbol check for entry r_idx against signs and all later used entries
    always_comb begin
        chk_sym = sym_of(r_sym_lo, r_sym_hi, 4'(r_idx));
        sym_bad = (chk_sym == CH_MINUS) || (chk_sym == CH_PLUS);
        for (int j = 0; j < NUM_SYMS; j++) begin
            if ((j > int'(r_idx)) && (j < int'(used_radix)) &&
                (sym_of(r_sym_lo, r_sym_hi, 4'(j)) == chk_sym)) begin
                sym_bad = 1'b1;
            end
        end
    end

    assign out_free = !r_out_valid || o_char_ch.ready;

    // Handshakes and output port
    assign i_value_ch.ready  = (r_state == ST_IDLE);
    assign i_cfg_ch.ready    = 1'b1;
    assign o_char_ch.valid   = r_out_valid;
    assign o_char_ch.character = r_char;
    assign o_char_ch.last    = r_last;

    // Next state and datapath
    always_comb begin
        n_radix     = r_radix;
        n_sym_lo    = r_sym_lo;
        n_sym_hi    = r_sym_hi;
        n_state     = r_state;
        n_neg       = r_neg;
        n_q         = r_q;
        n_rem       = r_rem;
        n_bit       = r_bit;
        n_idx       = r_idx;
        n_stk       = r_stk;
        n_nd        = r_nd;
        n_out_valid = r_out_valid;
        n_char      = r_char;
        n_last      = r_last;

        // configuration writes
        if (i_cfg_ch.valid) begin
            case (i_cfg_ch.index)
                CFG_RADIX:    n_radix  = i_cfg_ch.data[RADIX_W-1:0];
                CFG_SYM_LOW:  n_sym_lo = i_cfg_ch.data;
                CFG_SYM_HIGH: n_sym_hi = i_cfg_ch.data;
                default:      ;
            endcase
        end

        // output beat taken
        if (r_out_valid && o_char_ch.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_value_ch.valid) begin
                    n_neg = i_value_ch.value[VALUE_W-1];
                    n_q   = i_value_ch.value[VALUE_W-1] ?
                            (VALUE_W'(0) - VALUE_W'(i_value_ch.value)) :
                            VALUE_W'(i_value_ch.value);
                    n_idx = '0;
                    n_state = (used_radix < RAD_W'(2)) ? ST_IDLE : ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sym_bad) begin
                    n_state = ST_IDLE;
                end else if (r_idx == RW'(used_radix - RAD_W'(1))) begin
                    n_state = ST_DIV;
                    n_rem   = '0;
                    n_bit   = '0;
                    n_nd    = '0;
                end else begin
                    n_idx = r_idx + RW'(1);
                end
            end
            ST_DIV: begin
                n_q   = q_new;
                n_rem = rem_new;
                n_bit = r_bit + BIT_W'(1);
                if (r_bit == BIT_W'(VALUE_W - 1)) begin
                    // digit done: push remainder, restart on the quotient
                    n_stk = {r_stk[STK_W-RW-1:0], rem_new};
                    n_nd  = r_nd + CNT_W'(1);
                    n_rem = '0;
                    if ((q_new == '0) || (r_nd + CNT_W'(1) == CNT_W'(VALUE_W))) begin
                        n_state = r_neg ? ST_SIGN : ST_DIGIT;
                    end
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = CH_MINUS;
                    n_last      = 1'b0;
                    n_state     = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                // pop most significant digit from the low end of the stack
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = sym_of(r_sym_lo, r_sym_hi, 4'(r_stk[RW-1:0]));
                    n_last      = (r_nd == CNT_W'(1));
                    n_stk       = r_stk >> RW;
                    n_nd        = r_nd - CNT_W'(1);
                    if (r_nd == CNT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_radix     <= '0;
            r_sym_lo    <= '0;
            r_sym_hi    <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_radix     <= n_radix;
            r_sym_lo    <= n_sym_lo;
            r_sym_hi    <= n_sym_hi;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_neg  <= n_neg;
        r_q    <= n_q;
        r_rem  <= n_rem;
        r_bit  <= n_bit;
        r_idx  <= n_idx;
        r_stk  <= n_stk;
        r_nd   <= n_nd;
        r_char <= n_char;
        r_last <= n_last;
    end

endmodule
